[hw/rtl/sgbu_pkg.sv]
// Package with the widths, register addresses, stage types and divider step of the upscaler.
`timescale 1ns / 1ps

package sgbu_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_STEP   = 64;

    localparam int COORD_W = 8;
    localparam int DIM_W   = 9;
    localparam int STEP_W  = 7;
    localparam int FRAC_W  = 6;
    localparam int CH_W    = 16;
    localparam int NN_W    = 13;
    localparam int REM_W   = 14;
    localparam int TOP_W   = 22;
    localparam int ACC_W   = 28;
    localparam int PADDR_W = 4;
    localparam int ADDR_W  = 2 * COORD_W;
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int DIV_STEPS = 4;
    localparam int QDIV_STAGES = 4;

    localparam logic [PADDR_W-1:0] REG_FRAME_WIDTH  = 4'h0;
    localparam logic [PADDR_W-1:0] REG_FRAME_HEIGHT = 4'h4;
    localparam logic [PADDR_W-1:0] REG_GRID_STEP    = 4'h8;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef logic [2:0][CH_W-1:0] pix_t;

    typedef struct packed {
        logic               vld;
        logic               kind;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        pix_t               pix;
    } in_stage_t;

    typedef struct packed {
        logic               vld;
        logic               kind;
        logic               in_frame;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        pix_t               pix;
        logic [REM_W-1:0]   rem_c;
        logic [REM_W-1:0]   rem_r;
    } grid_stage_t;

    typedef struct packed {
        logic              vld;
        logic              oor;
        logic [FRAC_W-1:0] i;
        logic [FRAC_W-1:0] j;
    } fetch_stage_t;

    typedef struct packed {
        logic                       vld;
        logic                       oor;
        logic [FRAC_W-1:0]          j;
        logic [2:0][TOP_W-1:0]      top;
        logic [2:0][TOP_W-1:0]      bot;
    } blend_stage_t;

    typedef struct packed {
        logic                  vld;
        logic                  oor;
        logic [2:0][REM_W-1:0] rem;
        logic [2:0][CH_W-1:0]  quo;
        logic [2:0][CH_W-1:0]  low;
    } qdiv_stage_t;

    typedef struct packed {
        logic oor;
        pix_t pix;
    } out_stage_t;

    // One restoring division step: the top bit is the quotient bit, the rest the remainder.
    function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem, input logic b,
                                                input logic [NN_W-1:0] d);
        logic [REM_W-1:0] t;
        t = {rem[REM_W-2:0], b};
        if (t >= REM_W'(d)) begin
            return {1'b1, t - REM_W'(d)};
        end else begin
            return {1'b0, t};
        end
    endfunction

endpackage

[hw/rtl/sparse_grid_bilinear_upscale_unit.sv]
// Top level of the sparse grid bilinear upscaler: configuration, sample store and blend pipeline.
// The unit takes one request per clock while its skid stage is empty, loads and reads alike, and
// presents a result for each read; loads and off-grid loads give no result. The column and row
// are split into grid origin and offset by a restoring divider of four steps per stage, the four
// grid samples are fetched together from two copies of the 64K x 48 sample store with two read
// ports each, and the division by the squared step runs over four further stages. A skid stage at
// the output lets one more request in while a result waits. Samples must be loaded before they
// are read; the store is not cleared after reset.
`timescale 1ns / 1ps

module sparse_grid_bilinear_upscale_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sgbu_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_kind,
    input  logic [sgbu_pkg::COORD_W-1:0] s_col,
    input  logic [sgbu_pkg::COORD_W-1:0] s_row,
    input  logic [sgbu_pkg::CH_W-1:0]    s_red_in,
    input  logic [sgbu_pkg::CH_W-1:0]    s_green_in,
    input  logic [sgbu_pkg::CH_W-1:0]    s_blue_in,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [sgbu_pkg::CH_W-1:0]    m_red_out,
    output logic [sgbu_pkg::CH_W-1:0]    m_green_out,
    output logic [sgbu_pkg::CH_W-1:0]    m_blue_out,
    output logic                         m_out_of_range
);

    logic [sgbu_pkg::DIM_W-1:0]  frame_width_reg;
    logic [sgbu_pkg::DIM_W-1:0]  frame_height_reg;
    logic [sgbu_pkg::STEP_W-1:0] grid_step_reg;
    logic [sgbu_pkg::DIM_W-1:0]  w_eff;
    logic [sgbu_pkg::DIM_W-1:0]  h_eff;
    logic [sgbu_pkg::STEP_W-1:0] n_eff;
    logic [sgbu_pkg::NN_W-1:0]   nn;
    logic                        adv;

    sgbu_pkg::in_stage_t    s1_reg, s1_next;
    sgbu_pkg::grid_stage_t  s2_reg, s2_next;
    sgbu_pkg::grid_stage_t  s3_reg, s3_next;
    sgbu_pkg::fetch_stage_t s4_reg, s4_next;
    sgbu_pkg::blend_stage_t s5_reg, s5_next;
    sgbu_pkg::qdiv_stage_t  s6_reg, s6_next;
    sgbu_pkg::qdiv_stage_t  qd_reg [sgbu_pkg::QDIV_STAGES];
    sgbu_pkg::qdiv_stage_t  qd_next [sgbu_pkg::QDIV_STAGES];
    sgbu_pkg::qdiv_stage_t  qd_src [sgbu_pkg::QDIV_STAGES];
    sgbu_pkg::out_stage_t   fin;
    sgbu_pkg::out_stage_t   o_reg;
    sgbu_pkg::out_stage_t   k_reg;
    logic                   o_valid_reg;
    logic                   k_valid_reg;

    sgbu_pkg::pix_t mem_a [sgbu_pkg::DEPTH];
    sgbu_pkg::pix_t mem_b [sgbu_pkg::DEPTH];
    sgbu_pkg::pix_t rd00_reg, rd01_reg, rd10_reg, rd11_reg;

    logic [sgbu_pkg::COORD_W-1:0] c0, r0, c1, r1;
    logic                         has_c, has_r, do_write;
    logic [sgbu_pkg::ADDR_W-1:0]  wr_addr;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= sgbu_pkg::DIM_W'(sgbu_pkg::MAX_WIDTH);
            frame_height_reg <= sgbu_pkg::DIM_W'(sgbu_pkg::MAX_HEIGHT);
            grid_step_reg    <= sgbu_pkg::STEP_W'(4);
        end else if (psel && penable && pwrite) begin
            case (paddr)
                sgbu_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[sgbu_pkg::DIM_W-1:0];
                sgbu_pkg::REG_FRAME_HEIGHT: frame_height_reg <= pwdata[sgbu_pkg::DIM_W-1:0];
                sgbu_pkg::REG_GRID_STEP:    grid_step_reg    <= pwdata[sgbu_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            sgbu_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width_reg);
            sgbu_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height_reg);
            sgbu_pkg::REG_GRID_STEP:    prdata = 32'(grid_step_reg);
            default:                    prdata = 32'd0;
        endcase
    end

    always_comb begin
        if (frame_width_reg == '0) begin
            w_eff = sgbu_pkg::DIM_W'(1);
        end else if (frame_width_reg > sgbu_pkg::DIM_W'(sgbu_pkg::MAX_WIDTH)) begin
            w_eff = sgbu_pkg::DIM_W'(sgbu_pkg::MAX_WIDTH);
        end else begin
            w_eff = frame_width_reg;
        end
        if (frame_height_reg == '0) begin
            h_eff = sgbu_pkg::DIM_W'(1);
        end else if (frame_height_reg > sgbu_pkg::DIM_W'(sgbu_pkg::MAX_HEIGHT)) begin
            h_eff = sgbu_pkg::DIM_W'(sgbu_pkg::MAX_HEIGHT);
        end else begin
            h_eff = frame_height_reg;
        end
        if (grid_step_reg == '0) begin
            n_eff = sgbu_pkg::STEP_W'(1);
        end else if (grid_step_reg > sgbu_pkg::STEP_W'(sgbu_pkg::MAX_STEP)) begin
            n_eff = sgbu_pkg::STEP_W'(sgbu_pkg::MAX_STEP);
        end else begin
            n_eff = grid_step_reg;
        end
        nn = sgbu_pkg::NN_W'(n_eff * n_eff);
    end

    assign adv     = !k_valid_reg;
    assign s_ready = adv;

    always_comb begin
        s1_next.vld = s_valid;
        s1_next.kind = s_kind;
        s1_next.col = s_col;
        s1_next.row = s_row;
        s1_next.pix = {s_blue_in, s_green_in, s_red_in};
    end

    always_comb begin
        logic [sgbu_pkg::REM_W:0] rc, rr;
        s2_next.vld      = s1_reg.vld;
        s2_next.kind     = s1_reg.kind;
        s2_next.in_frame = ({1'b0, s1_reg.col} < w_eff) && ({1'b0, s1_reg.row} < h_eff);
        s2_next.col      = s1_reg.col;
        s2_next.row      = s1_reg.row;
        s2_next.pix      = s1_reg.pix;
        s2_next.rem_c    = '0;
        s2_next.rem_r    = '0;
        for (int k = 0; k < sgbu_pkg::DIV_STEPS; k++) begin
            rc = sgbu_pkg::div_step(s2_next.rem_c, s1_reg.col[7-k], sgbu_pkg::NN_W'(n_eff));
            rr = sgbu_pkg::div_step(s2_next.rem_r, s1_reg.row[7-k], sgbu_pkg::NN_W'(n_eff));
            s2_next.rem_c = rc[sgbu_pkg::REM_W-1:0];
            s2_next.rem_r = rr[sgbu_pkg::REM_W-1:0];
        end
    end

    always_comb begin
        logic [sgbu_pkg::REM_W:0] rc, rr;
        s3_next = s2_reg;
        for (int k = 0; k < sgbu_pkg::DIV_STEPS; k++) begin
            rc = sgbu_pkg::div_step(s3_next.rem_c, s2_reg.col[3-k], sgbu_pkg::NN_W'(n_eff));
            rr = sgbu_pkg::div_step(s3_next.rem_r, s2_reg.row[3-k], sgbu_pkg::NN_W'(n_eff));
            s3_next.rem_c = rc[sgbu_pkg::REM_W-1:0];
            s3_next.rem_r = rr[sgbu_pkg::REM_W-1:0];
        end
    end

    always_comb begin
        c0    = s3_reg.col - sgbu_pkg::COORD_W'(s3_reg.rem_c);
        r0    = s3_reg.row - sgbu_pkg::COORD_W'(s3_reg.rem_r);
        has_c = ({1'b0, c0} + sgbu_pkg::DIM_W'(n_eff)) < w_eff;
        has_r = ({1'b0, r0} + sgbu_pkg::DIM_W'(n_eff)) < h_eff;
        c1    = has_c ? c0 + sgbu_pkg::COORD_W'(n_eff) : c0;
        r1    = has_r ? r0 + sgbu_pkg::COORD_W'(n_eff) : r0;
        do_write = adv && s3_reg.vld && (s3_reg.kind == sgbu_pkg::KIND_LOAD) && s3_reg.in_frame &&
                   (s3_reg.rem_c == '0) && (s3_reg.rem_r == '0);
        wr_addr  = {s3_reg.row, s3_reg.col};
        s4_next.vld = s3_reg.vld && (s3_reg.kind == sgbu_pkg::KIND_READ);
        s4_next.oor = !s3_reg.in_frame;
        s4_next.i   = has_c ? s3_reg.rem_c[sgbu_pkg::FRAC_W-1:0] : '0;
        s4_next.j   = has_r ? s3_reg.rem_r[sgbu_pkg::FRAC_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem_a[wr_addr] <= s3_reg.pix;
        end
        if (adv) begin
            rd00_reg <= mem_a[{r0, c0}];
            rd01_reg <= mem_a[{r0, c1}];
        end
    end

    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem_b[wr_addr] <= s3_reg.pix;
        end
        if (adv) begin
            rd10_reg <= mem_b[{r1, c0}];
            rd11_reg <= mem_b[{r1, c1}];
        end
    end

    always_comb begin
        logic [sgbu_pkg::STEP_W-1:0] ni;
        logic [sgbu_pkg::STEP_W-1:0] iw;
        iw = sgbu_pkg::STEP_W'(s4_reg.i);
        ni = n_eff - iw;
        s5_next.vld = s4_reg.vld;
        s5_next.oor = s4_reg.oor;
        s5_next.j   = s4_reg.j;
        for (int c = 0; c < 3; c++) begin
            s5_next.top[c] = sgbu_pkg::TOP_W'(rd00_reg[c] * ni + rd01_reg[c] * iw);
            s5_next.bot[c] = sgbu_pkg::TOP_W'(rd10_reg[c] * ni + rd11_reg[c] * iw);
        end
    end

    always_comb begin
        logic [sgbu_pkg::STEP_W-1:0] nj;
        logic [sgbu_pkg::STEP_W-1:0] jw;
        logic [sgbu_pkg::ACC_W-1:0]  acc;
        jw = sgbu_pkg::STEP_W'(s5_reg.j);
        nj = n_eff - jw;
        s6_next.vld = s5_reg.vld;
        s6_next.oor = s5_reg.oor;
        s6_next.quo = '0;
        s6_next.rem = '0;
        s6_next.low = '0;
        for (int c = 0; c < 3; c++) begin
            acc = sgbu_pkg::ACC_W'(s5_reg.top[c] * nj + s5_reg.bot[c] * jw + (nn >> 1));
            s6_next.rem[c] = sgbu_pkg::REM_W'(acc[sgbu_pkg::ACC_W-1:sgbu_pkg::CH_W]);
            s6_next.low[c] = acc[sgbu_pkg::CH_W-1:0];
        end
    end

    for (genvar g = 0; g < sgbu_pkg::QDIV_STAGES; g++) begin : g_qdiv
        if (g == 0) begin : g_first
            assign qd_src[g] = s6_reg;
        end else begin : g_rest
            assign qd_src[g] = qd_reg[g-1];
        end

        always_comb begin
            logic [sgbu_pkg::REM_W:0] r;
            qd_next[g] = qd_src[g];
            for (int k = 0; k < sgbu_pkg::DIV_STEPS; k++) begin
                for (int c = 0; c < 3; c++) begin
                    r = sgbu_pkg::div_step(qd_next[g].rem[c],
                                           qd_next[g].low[c][sgbu_pkg::CH_W-1], nn);
                    qd_next[g].quo[c] = {qd_next[g].quo[c][sgbu_pkg::CH_W-2:0],
                                         r[sgbu_pkg::REM_W]};
                    qd_next[g].rem[c] = r[sgbu_pkg::REM_W-1:0];
                    qd_next[g].low[c] = {qd_next[g].low[c][sgbu_pkg::CH_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                qd_reg[g].vld <= 1'b0;
            end else if (adv) begin
                qd_reg[g] <= qd_next[g];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.vld <= 1'b0;
            s2_reg.vld <= 1'b0;
            s3_reg.vld <= 1'b0;
            s4_reg.vld <= 1'b0;
            s5_reg.vld <= 1'b0;
            s6_reg.vld <= 1'b0;
        end else if (adv) begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
        end
    end

    always_comb begin
        fin.oor = qd_reg[sgbu_pkg::QDIV_STAGES-1].oor;
        fin.pix = fin.oor ? '0 : qd_reg[sgbu_pkg::QDIV_STAGES-1].quo;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
            k_valid_reg <= 1'b0;
        end else if (k_valid_reg) begin
            if (m_ready) begin
                o_reg       <= k_reg;
                k_valid_reg <= 1'b0;
            end
        end else if (!o_valid_reg || m_ready) begin
            o_valid_reg <= qd_reg[sgbu_pkg::QDIV_STAGES-1].vld;
            o_reg       <= fin;
        end else if (qd_reg[sgbu_pkg::QDIV_STAGES-1].vld) begin
            k_reg       <= fin;
            k_valid_reg <= 1'b1;
        end
    end

    assign m_valid        = o_valid_reg;
    assign m_red_out      = o_reg.pix[0];
    assign m_green_out    = o_reg.pix[1];
    assign m_blue_out     = o_reg.pix[2];
    assign m_out_of_range = o_reg.oor;

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        k_valid_reg |-> o_valid_reg)
        else $error("Skid stage holds a request while the output stage is empty.");

    a_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(qd_reg[sgbu_pkg::QDIV_STAGES-1].vld))
        else $error("Pipeline tail moved while the skid stage was full.");

    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_of_range) |->
            (m_red_out == '0) && (m_green_out == '0) && (m_blue_out == '0))
        else $error("Out-of-range result carries non-zero channels.");

endmodule

[bench/tb_sparse_grid_bilinear_upscale_unit.sv]
// Self-checking testbench for the sparse grid bilinear upscaler, with its own pixel predictor.
`timescale 1ns / 1ps

module tb_sparse_grid_bilinear_upscale_unit;

    typedef struct {
        logic [sgbu_pkg::CH_W-1:0] red;
        logic [sgbu_pkg::CH_W-1:0] green;
        logic [sgbu_pkg::CH_W-1:0] blue;
        logic                      oor;
    } pixel_t;

    typedef struct {
        logic                      kind;
        int                        col;
        int                        row;
        logic [sgbu_pkg::CH_W-1:0] red;
        logic [sgbu_pkg::CH_W-1:0] green;
        logic [sgbu_pkg::CH_W-1:0] blue;
        bit                        typed;
        pixel_t                    want;
        bit                        shrink_frame;
    } step_row_t;

    logic aclk;
    logic aresetn;
    logic psel, penable, pwrite;
    logic [sgbu_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic s_valid, s_ready, s_kind;
    logic [sgbu_pkg::COORD_W-1:0] s_col, s_row;
    logic [sgbu_pkg::CH_W-1:0] s_red_in, s_green_in, s_blue_in;
    logic m_valid, m_ready;
    logic [sgbu_pkg::CH_W-1:0] m_red_out, m_green_out, m_blue_out;
    logic m_out_of_range;

    logic [3*sgbu_pkg::CH_W-1:0] grid_mem [sgbu_pkg::DEPTH];
    logic [sgbu_pkg::DIM_W-1:0]  frame_w_reg;
    logic [sgbu_pkg::DIM_W-1:0]  frame_h_reg;
    logic [sgbu_pkg::STEP_W-1:0] step_reg;
    pixel_t pending_pix [$];
    step_row_t steps [$];
    bit failed;
    bit quiet;
    bit hold_req;

    sparse_grid_bilinear_upscale_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind), .s_col(s_col), .s_row(s_row),
        .s_red_in(s_red_in), .s_green_in(s_green_in), .s_blue_in(s_blue_in),
        .m_valid(m_valid), .m_ready(m_ready), .m_red_out(m_red_out),
        .m_green_out(m_green_out), .m_blue_out(m_blue_out), .m_out_of_range(m_out_of_range)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic int clamp_dim(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int eff_w();
        return clamp_dim(frame_w_reg, sgbu_pkg::MAX_WIDTH);
    endfunction

    function automatic int eff_h();
        return clamp_dim(frame_h_reg, sgbu_pkg::MAX_HEIGHT);
    endfunction

    function automatic int eff_n();
        return clamp_dim(step_reg, sgbu_pkg::MAX_STEP);
    endfunction

    function automatic logic [sgbu_pkg::CH_W-1:0] blend_channel(int ch, int r0, int r1, int c0,
                                                                int c1, longint n, longint i,
                                                                longint j);
        longint s00, s01, s10, s11, top, bot, nn;
        s00 = grid_mem[r0 * sgbu_pkg::MAX_WIDTH + c0][ch*sgbu_pkg::CH_W +: sgbu_pkg::CH_W];
        s01 = grid_mem[r0 * sgbu_pkg::MAX_WIDTH + c1][ch*sgbu_pkg::CH_W +: sgbu_pkg::CH_W];
        s10 = grid_mem[r1 * sgbu_pkg::MAX_WIDTH + c0][ch*sgbu_pkg::CH_W +: sgbu_pkg::CH_W];
        s11 = grid_mem[r1 * sgbu_pkg::MAX_WIDTH + c1][ch*sgbu_pkg::CH_W +: sgbu_pkg::CH_W];
        top = s00 * (n - i) + s01 * i;
        bot = s10 * (n - i) + s11 * i;
        nn = n * n;
        return sgbu_pkg::CH_W'((top * (n - j) + bot * j + nn / 2) / nn);
    endfunction

    function automatic pixel_t upscale_pixel(int col, int row);
        pixel_t p;
        int w, h, n, c0, r0, c1, r1;
        longint i, j;
        w = eff_w();
        h = eff_h();
        n = eff_n();
        p = '{red: '0, green: '0, blue: '0, oor: 1'b1};
        if (col >= w || row >= h) return p;
        c0 = (col / n) * n;
        r0 = (row / n) * n;
        c1 = c0;
        r1 = r0;
        i = 0;
        j = 0;
        if (c0 + n < w) begin
            c1 = c0 + n;
            i = col - c0;
        end
        if (r0 + n < h) begin
            r1 = r0 + n;
            j = row - r0;
        end
        p.red = blend_channel(2, r0, r1, c0, c1, n, i, j);
        p.green = blend_channel(1, r0, r1, c0, c1, n, i, j);
        p.blue = blend_channel(0, r0, r1, c0, c1, n, i, j);
        p.oor = 1'b0;
        return p;
    endfunction

    task automatic send_request(logic k, int col, int row, logic [sgbu_pkg::CH_W-1:0] rd,
                                logic [sgbu_pkg::CH_W-1:0] gr, logic [sgbu_pkg::CH_W-1:0] bl,
                                bit typed, pixel_t want);
        bit acc;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_kind = k;
        s_col = sgbu_pkg::COORD_W'(col);
        s_row = sgbu_pkg::COORD_W'(row);
        s_red_in = rd;
        s_green_in = gr;
        s_blue_in = bl;
        forever begin
            @(posedge aclk);
            acc = s_ready;
            @(negedge aclk);
            if (acc) break;
        end
        if (k == sgbu_pkg::KIND_READ) begin
            pending_pix.push_back(typed ? want : upscale_pixel(col, row));
        end else if (col < eff_w() && row < eff_h() && col % eff_n() == 0 && row % eff_n() == 0)
        begin
            grid_mem[row * sgbu_pkg::MAX_WIDTH + col] = {rd, gr, bl};
        end
    endtask

    task automatic write_reg(logic [sgbu_pkg::PADDR_W-1:0] addr, logic [31:0] data);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = addr;
        pwdata = data;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        case (addr)
            sgbu_pkg::REG_FRAME_WIDTH: frame_w_reg = data[sgbu_pkg::DIM_W-1:0];
            sgbu_pkg::REG_FRAME_HEIGHT: frame_h_reg = data[sgbu_pkg::DIM_W-1:0];
            sgbu_pkg::REG_GRID_STEP: step_reg = data[sgbu_pkg::STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (pending_pix.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic add_step(logic k, int col, int row, logic [sgbu_pkg::CH_W-1:0] rd,
                            logic [sgbu_pkg::CH_W-1:0] gr, logic [sgbu_pkg::CH_W-1:0] bl,
                            bit typed, pixel_t want, bit shrink = 0);
        steps.push_back('{k, col, row, rd, gr, bl, typed, want, shrink});
    endtask

    task automatic run_phase(int w_raw, int h_raw, int n_raw, int count, bit press = 0);
        int w, h, n, col, row, lim_c, lim_r;
        pixel_t none;
        none = '{red: '0, green: '0, blue: '0, oor: 1'b0};
        drain();
        write_reg(sgbu_pkg::REG_FRAME_WIDTH, w_raw);
        write_reg(sgbu_pkg::REG_FRAME_HEIGHT, h_raw);
        write_reg(sgbu_pkg::REG_GRID_STEP, n_raw);
        w = eff_w();
        h = eff_h();
        n = eff_n();
        for (row = 0; row < h; row += n) begin
            for (col = 0; col < w; col += n) begin
                send_request(sgbu_pkg::KIND_LOAD, col, row, $urandom, $urandom, $urandom, 0,
                             none);
            end
        end
        lim_c = (w > 255) ? 255 : w;
        lim_r = (h > 255) ? 255 : h;
        if (press) hold_req = 1;
        repeat (count) begin
            if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 3) == 0) begin
                    col = $urandom_range(0, 255);
                    row = $urandom_range(0, 255);
                end else begin
                    col = $urandom_range(0, lim_c);
                    row = $urandom_range(0, lim_r);
                end
                send_request(sgbu_pkg::KIND_READ, col, row, $urandom, $urandom, $urandom, 0,
                             none);
            end else begin
                if ($urandom_range(0, 1) == 0) begin
                    col = $urandom_range(0, (w - 1) / n) * n;
                    row = $urandom_range(0, (h - 1) / n) * n;
                end else begin
                    col = $urandom_range(0, 255);
                    row = $urandom_range(0, 255);
                end
                send_request(sgbu_pkg::KIND_LOAD, col, row, $urandom, $urandom, $urandom, 0,
                             none);
            end
        end
    endtask

    initial begin
        int stall, hold;
        m_ready = 1'b1;
        stall = 0;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 0;
                hold = 300;
            end
            if (hold > 0) begin
                hold--;
                m_ready = 1'b0;
            end else if (quiet) begin
                m_ready = 1'b1;
            end else if (stall > 0) begin
                stall--;
                m_ready = 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 19) - 1;
                m_ready = 1'b0;
            end else begin
                m_ready = 1'b1;
            end
            @(posedge aclk);
            if (m_valid && m_ready) begin
                pixel_t got, want;
                got = '{m_red_out, m_green_out, m_blue_out, m_out_of_range};
                if (pending_pix.size() == 0) begin
                    $display("%0t: result with no request pending: %h %h %h %b", $realtime,
                             got.red, got.green, got.blue, got.oor);
                    failed = 1;
                end else begin
                    want = pending_pix.pop_front();
                    if (got.red !== want.red) begin
                        $display("%0t: red_out expected %h actual %h", $realtime, want.red,
                                 got.red);
                        failed = 1;
                    end
                    if (got.green !== want.green) begin
                        $display("%0t: green_out expected %h actual %h", $realtime, want.green,
                                 got.green);
                        failed = 1;
                    end
                    if (got.blue !== want.blue) begin
                        $display("%0t: blue_out expected %h actual %h", $realtime, want.blue,
                                 got.blue);
                        failed = 1;
                    end
                    if (got.oor !== want.oor) begin
                        $display("%0t: out_of_range expected %b actual %b", $realtime, want.oor,
                                 got.oor);
                        failed = 1;
                    end
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("FAIL sparse_grid_bilinear_upscale_unit");
        $finish;
    end

    initial begin
        pixel_t ones, zero, oor, tail, cut;
        step_row_t st;
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_kind = sgbu_pkg::KIND_LOAD;
        s_col = '0;
        s_row = '0;
        s_red_in = '0;
        s_green_in = '0;
        s_blue_in = '0;
        failed = 0;
        quiet = 0;
        hold_req = 0;
        frame_w_reg = 9'd256;
        frame_h_reg = 9'd256;
        step_reg = 7'd4;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        ones = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0};
        zero = '{16'h0000, 16'h0000, 16'h0000, 1'b0};
        oor = '{16'h0000, 16'h0000, 16'h0000, 1'b1};
        tail = '{16'h1234, 16'h5678, 16'h9ABC, 1'b0};
        cut = '{16'hAAAA, 16'h5555, 16'h0001, 1'b0};
        add_step(sgbu_pkg::KIND_LOAD, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, zero);
        add_step(sgbu_pkg::KIND_LOAD, 4, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, zero);
        add_step(sgbu_pkg::KIND_LOAD, 0, 4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, zero);
        add_step(sgbu_pkg::KIND_LOAD, 4, 4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, zero);
        add_step(sgbu_pkg::KIND_READ, 2, 2, 0, 0, 0, 1, ones);
        add_step(sgbu_pkg::KIND_READ, 0, 0, 0, 0, 0, 1, ones);
        add_step(sgbu_pkg::KIND_LOAD, 1, 1, 0, 0, 0, 0, zero);
        add_step(sgbu_pkg::KIND_READ, 1, 1, 0, 0, 0, 1, ones);
        add_step(sgbu_pkg::KIND_LOAD, 0, 0, 16'h0000, 16'h0000, 16'h0000, 0, zero);
        add_step(sgbu_pkg::KIND_READ, 0, 0, 0, 0, 0, 1, zero);
        add_step(sgbu_pkg::KIND_READ, 3, 1, 0, 0, 0, 0, zero);
        add_step(sgbu_pkg::KIND_LOAD, 252, 252, 16'h1234, 16'h5678, 16'h9ABC, 0, zero);
        add_step(sgbu_pkg::KIND_READ, 255, 255, 0, 0, 0, 1, tail);
        add_step(sgbu_pkg::KIND_READ, 254, 253, 0, 0, 0, 1, tail);
        add_step(sgbu_pkg::KIND_LOAD, 196, 96, 16'hAAAA, 16'h5555, 16'h0001, 0, zero, 1);
        add_step(sgbu_pkg::KIND_READ, 199, 99, 0, 0, 0, 1, cut);
        add_step(sgbu_pkg::KIND_READ, 200, 5, 0, 0, 0, 1, oor);
        add_step(sgbu_pkg::KIND_READ, 5, 100, 0, 0, 0, 1, oor);
        add_step(sgbu_pkg::KIND_READ, 255, 255, 0, 0, 0, 1, oor);
        add_step(sgbu_pkg::KIND_LOAD, 200, 0, 16'h7777, 16'h7777, 16'h7777, 0, zero);
        add_step(sgbu_pkg::KIND_READ, 2, 2, 0, 0, 0, 0, zero);
        foreach (steps[k]) begin
            st = steps[k];
            if (st.shrink_frame) begin
                drain();
                write_reg(sgbu_pkg::REG_FRAME_WIDTH, 200);
                write_reg(sgbu_pkg::REG_FRAME_HEIGHT, 100);
            end
            send_request(st.kind, st.col, st.row, st.red, st.green, st.blue, st.typed, st.want);
        end

        run_phase(256, 256, 64, 60);
        run_phase(0, 0, 0, 50);
        run_phase(511, 1, 100, 50);
        run_phase(17, 9, 4, 60);
        run_phase(256, 256, 16, 80, 1);
        run_phase(100, 60, 7, 60);
        run_phase(8, 6, 1, 60);
        drain();
        quiet = 1;
        run_phase(256, 256, 127, 80);
        drain();
        if (!failed) begin
            $display("PASS sparse_grid_bilinear_upscale_unit");
        end else begin
            $display("FAIL sparse_grid_bilinear_upscale_unit");
        end
        $finish;
    end
endmodule

[filelist.f]
hw/rtl/sgbu_pkg.sv
hw/rtl/sparse_grid_bilinear_upscale_unit.sv
bench/tb_sparse_grid_bilinear_upscale_unit.sv
